>>> src/hcfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfb_pkg
// Shared types and constants for the header and checksum frame builder.
// ----------------------------------------------------------------------------
package hcfb_pkg;

    localparam int HDR_LEN         = 20;
    localparam int ID_LEN          = 13;
    localparam int ID_HEAD_BYTES   = 5;
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int ID_HEAD_W       = 8 * ID_HEAD_BYTES;
    localparam int ID_TAIL_W       = 8 * (ID_LEN - ID_HEAD_BYTES);
    localparam int BYTE_IDX_W      = $clog2(HDR_LEN + 1);

    localparam logic [7:0] FRAME_KIND = 8'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_ID_HEAD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_TAIL = 2'd1;

    localparam logic ACTION_START   = 1'b0;
    localparam logic ACTION_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        CMD_HEADER,
        CMD_PAYLOAD,
        CMD_PAYLOAD_LAST
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  seq_number;
        logic [7:0]  version;
        logic [3:0]  security;
        logic [3:0]  reply_request;
        logic [7:0]  data_type;
        logic [15:0] payload_length;
        logic [7:0]  data;
        logic [7:0]  checksum;
    } cmd_t;

endpackage

`default_nettype wire

>>> src/hcfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfb_front
// Accepts input requests, tracks the open frame and its running sum, and turns
// each start and in-frame payload request into a command for the serializer.
// ----------------------------------------------------------------------------
module hcfb_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_action,
    input  wire logic [7:0]   s_seq_number,
    input  wire logic [7:0]   s_version,
    input  wire logic [3:0]   s_security,
    input  wire logic [3:0]   s_reply_request,
    input  wire logic [7:0]   s_data_type,
    input  wire logic [15:0]  s_payload_length,
    input  wire logic [7:0]   s_payload_byte,
    input  wire logic         queue_full,
    output logic              push,
    output hcfb_pkg::cmd_t    push_cmd
);
    import hcfb_pkg::*;

    logic        frame_open_reg, frame_open_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic        accept;
    logic [7:0]  sum_plus;

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign sum_plus = running_sum_reg + s_payload_byte;

    always_comb begin
        frame_open_next      = frame_open_reg;
        bytes_remaining_next = bytes_remaining_reg;
        running_sum_next     = running_sum_reg;
        push                 = 1'b0;

        push_cmd                = '0;
        push_cmd.kind           = CMD_HEADER;
        push_cmd.seq_number     = s_seq_number;
        push_cmd.version        = s_version;
        push_cmd.security       = s_security;
        push_cmd.reply_request  = s_reply_request;
        push_cmd.data_type      = s_data_type;
        push_cmd.payload_length = s_payload_length;
        push_cmd.data           = s_payload_byte;
        push_cmd.checksum       = sum_plus;

        if (accept) begin
            if (s_action == ACTION_START) begin
                push                 = 1'b1;
                running_sum_next     = 8'd0;
                frame_open_next      = (s_payload_length != 16'd0);
                bytes_remaining_next = s_payload_length;
            end else if (frame_open_reg) begin
                push                 = 1'b1;
                bytes_remaining_next = bytes_remaining_reg - 16'd1;
                if (bytes_remaining_reg == 16'd1) begin
                    push_cmd.kind    = CMD_PAYLOAD_LAST;
                    frame_open_next  = 1'b0;
                    running_sum_next = 8'd0;
                end else begin
                    push_cmd.kind    = CMD_PAYLOAD;
                    running_sum_next = sum_plus;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg      <= 1'b0;
            bytes_remaining_reg <= 16'd0;
            running_sum_reg     <= 8'd0;
        end else begin
            frame_open_reg      <= frame_open_next;
            bytes_remaining_reg <= bytes_remaining_next;
            running_sum_reg     <= running_sum_next;
        end
    end

endmodule

`default_nettype wire

>>> src/hcfb_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfb_cmd_fifo
// Short command queue between the front end and the serializer.
// ----------------------------------------------------------------------------
module hcfb_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire hcfb_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output hcfb_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                empty
);
    import hcfb_pkg::*;

    localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cmd_t             mem [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(CMD_QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/hcfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcfb_back
// Serializer that expands queued commands into frame bytes and holds each
// byte in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module hcfb_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire hcfb_pkg::cmd_t                    head_cmd,
    input  wire logic                              queue_empty,
    output logic                                   pop,
    input  wire logic [hcfb_pkg::ID_HEAD_W-1:0]    device_id_head,
    input  wire logic [hcfb_pkg::ID_TAIL_W-1:0]    device_id_tail,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [7:0]                             m_out_byte,
    output logic                                   m_frame_end
);
    import hcfb_pkg::*;

    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  frame_end_reg, frame_end_next;
    logic                  step;
    logic [BYTE_IDX_W-1:0] last_idx;
    logic [7:0]            sel_byte;
    logic                  sel_end;
    logic [7:0]            hdr_byte;

    assign step = (!m_valid_reg || m_ready) && !queue_empty;

    always_comb begin
        case (idx_reg)
            BYTE_IDX_W'(0):  hdr_byte = head_cmd.seq_number;
            BYTE_IDX_W'(1):  hdr_byte = head_cmd.version;
            BYTE_IDX_W'(2):  hdr_byte = {head_cmd.security, head_cmd.reply_request};
            BYTE_IDX_W'(3):  hdr_byte = FRAME_KIND;
            BYTE_IDX_W'(4):  hdr_byte = device_id_head[39:32];
            BYTE_IDX_W'(5):  hdr_byte = device_id_head[31:24];
            BYTE_IDX_W'(6):  hdr_byte = device_id_head[23:16];
            BYTE_IDX_W'(7):  hdr_byte = device_id_head[15:8];
            BYTE_IDX_W'(8):  hdr_byte = device_id_head[7:0];
            BYTE_IDX_W'(9):  hdr_byte = device_id_tail[63:56];
            BYTE_IDX_W'(10): hdr_byte = device_id_tail[55:48];
            BYTE_IDX_W'(11): hdr_byte = device_id_tail[47:40];
            BYTE_IDX_W'(12): hdr_byte = device_id_tail[39:32];
            BYTE_IDX_W'(13): hdr_byte = device_id_tail[31:24];
            BYTE_IDX_W'(14): hdr_byte = device_id_tail[23:16];
            BYTE_IDX_W'(15): hdr_byte = device_id_tail[15:8];
            BYTE_IDX_W'(16): hdr_byte = device_id_tail[7:0];
            BYTE_IDX_W'(17): hdr_byte = head_cmd.data_type;
            BYTE_IDX_W'(18): hdr_byte = head_cmd.payload_length[15:8];
            BYTE_IDX_W'(19): hdr_byte = head_cmd.payload_length[7:0];
            default:         hdr_byte = 8'd0;
        endcase
    end

    always_comb begin
        case (head_cmd.kind)
            CMD_HEADER: begin
                last_idx = (head_cmd.payload_length == 16'd0) ?
                           BYTE_IDX_W'(HDR_LEN) : BYTE_IDX_W'(HDR_LEN - 1);
                sel_byte = hdr_byte;
                sel_end  = (idx_reg == BYTE_IDX_W'(HDR_LEN));
            end
            CMD_PAYLOAD_LAST: begin
                last_idx = BYTE_IDX_W'(1);
                sel_byte = (idx_reg == '0) ? head_cmd.data : head_cmd.checksum;
                sel_end  = (idx_reg != '0);
            end
            default: begin
                last_idx = '0;
                sel_byte = head_cmd.data;
                sel_end  = 1'b0;
            end
        endcase
    end

    always_comb begin
        idx_next       = idx_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        pop            = 1'b0;
        if (step) begin
            m_valid_next   = 1'b1;
            out_byte_next  = sel_byte;
            frame_end_next = sel_end;
            if (idx_reg == last_idx) begin
                pop      = 1'b1;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg  <= out_byte_next;
        frame_end_reg <= frame_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_frame_end = frame_end_reg;

endmodule

`default_nettype wire

>>> src/header_checksum_frame_builder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// header_checksum_frame_builder_top
// Builds outgoing frames: header, passed-through payload and an additive
// checksum byte that closes the frame.
//
// Requests arrive on the s_ channel. A start request produces 20 header
// bytes (21 with the checksum when the length is zero); a payload request
// produces its byte, and the final one of a frame also produces the checksum
// byte with m_frame_end set. Payload requests outside a frame are dropped.
// Frame bytes leave on the m_ channel, one per cycle at most. The device id
// is written through the cfg_ channel, which is always ready.
// With the queue empty and the output free, the first byte of a request
// passes the command queue, then the output register, before it is valid.
// Payload requests sustain one per cycle unless the output stalls; a start
// request emits its header and a final payload request its byte and checksum.
// A four-entry command queue lets new requests be taken while the output
// stalls; s_ready drops only when that queue is full. Reset clears the
// frame state, the queue and the device id registers.
// ----------------------------------------------------------------------------
module header_checksum_frame_builder_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [hcfb_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [hcfb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_action,
    input  wire logic [7:0]                            s_seq_number,
    input  wire logic [7:0]                            s_version,
    input  wire logic [3:0]                            s_security,
    input  wire logic [3:0]                            s_reply_request,
    input  wire logic [7:0]                            s_data_type,
    input  wire logic [15:0]                           s_payload_length,
    input  wire logic [7:0]                            s_payload_byte,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [7:0]                                 m_out_byte,
    output logic                                       m_frame_end
);
    import hcfb_pkg::*;

    logic [ID_HEAD_W-1:0] device_id_head_reg, device_id_head_next;
    logic [ID_TAIL_W-1:0] device_id_tail_reg, device_id_tail_next;
    logic                 push, pop, queue_full, queue_empty;
    cmd_t                 push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        device_id_head_next = device_id_head_reg;
        device_id_tail_next = device_id_tail_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ID_HEAD: device_id_head_next = cfg_data[ID_HEAD_W-1:0];
                CFG_ID_TAIL: device_id_tail_next = cfg_data[ID_TAIL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_head_reg <= '0;
            device_id_tail_reg <= '0;
        end else begin
            device_id_head_reg <= device_id_head_next;
            device_id_tail_reg <= device_id_tail_next;
        end
    end

    hcfb_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_seq_number     (s_seq_number),
        .s_version        (s_version),
        .s_security       (s_security),
        .s_reply_request  (s_reply_request),
        .s_data_type      (s_data_type),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .queue_full       (queue_full),
        .push             (push),
        .push_cmd         (push_cmd)
    );

    hcfb_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    hcfb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_cmd       (head_cmd),
        .queue_empty    (queue_empty),
        .pop            (pop),
        .device_id_head (device_id_head_reg),
        .device_id_tail (device_id_tail_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_frame_end    (m_frame_end)
    );

endmodule

`default_nettype wire
